### rtl/core/mandelbrot_escape_time_pixel_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel engine
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every clk edge outside reset
`define MET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clk edge, reset included
`define MET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MET_ASSERT(lbl, prop, msg)
`define MET_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, widths, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 64;
  localparam int ITER_W  = 16;
  localparam int COLOR_W = 8;
  localparam int STEP_W  = 31;
  localparam int IDX_W   = 3;

  // register indexes of the write port
  localparam logic [IDX_W-1:0] CFG_RE_ORIGIN  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_IM_ORIGIN  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_REAL_STEP  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_IMAG_STEP  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ITER_LIMIT = 3'd4;

  localparam logic signed [DATA_W-1:0] RST_RE_ORIGIN  = -32'sd134217728;
  localparam logic signed [DATA_W-1:0] RST_IM_ORIGIN  = -32'sd134217728;
  localparam logic [STEP_W-1:0]        RST_REAL_STEP  = 31'd335544;
  localparam logic [STEP_W-1:0]        RST_IMAG_STEP  = 31'd335544;
  localparam logic [ITER_W-1:0]        RST_ITER_LIMIT = 16'd500;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] re_origin;
    logic signed [DATA_W-1:0] im_origin;
    logic [STEP_W-1:0]        real_step;
    logic [STEP_W-1:0]        imag_step;
    logic [ITER_W-1:0]        iter_limit;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [ITER_W-1:0] count;
  } res_t;

  function automatic logic signed [PROD_W-1:0] sext32(input logic signed [DATA_W-1:0] v);
    sext32 = {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    sat32 = r;
  endfunction

endpackage

### rtl/core/met_mul.sv
// ----------------------------------------------------------------------------
// met_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module met_mul (
  input  logic                                clk,
  input  logic signed [met_pkg::DATA_W-1:0]   a,
  input  logic signed [met_pkg::DATA_W-1:0]   b,
  output logic signed [met_pkg::PROD_W-1:0]   prod
);
  import met_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### rtl/core/met_iter.sv
// ----------------------------------------------------------------------------
// met_iter
// Sequencer and z datapath: maps the pixel to c and runs z = z^2 + c on the
// shared multiplier, three products and one update step per iteration.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_defines.svh"

module met_iter #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  met_pkg::cfg_t         cfg,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  output logic                  idle,
  output met_pkg::res_t         res,
  input  logic                  res_take
);
  import met_pkg::*;

  localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MAP_R  = 9'b000000010,
    ST_MAP_I  = 9'b000000100,
    ST_MAP_C  = 9'b000001000,
    ST_SQ_R   = 9'b000010000,
    ST_SQ_I   = 9'b000100000,
    ST_CROSS  = 9'b001000000,
    ST_UPDATE = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t state;

  logic [COORD_BITS-1:0]    col_q;
  logic [COORD_BITS-1:0]    row_q;
  logic signed [DATA_W-1:0] cr;
  logic signed [DATA_W-1:0] ci;
  logic signed [DATA_W-1:0] zr;
  logic signed [DATA_W-1:0] zi;
  logic signed [PROD_W-1:0] rr;
  logic signed [PROD_W-1:0] ii;
  logic [ITER_W-1:0]        count;

  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [ITER_W-1:0]        iter_lim;
  logic [PROD_W-1:0]        mag;
  logic                     stop;
  logic signed [PROD_W-1:0] re_sum;
  logic signed [PROD_W-1:0] im_sum;

  met_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      ST_MAP_R: begin
        mul_a = DATA_W'(col_q);
        mul_b = DATA_W'(cfg.real_step);
      end
      ST_MAP_I: begin
        mul_a = DATA_W'(row_q);
        mul_b = DATA_W'(cfg.imag_step);
      end
      ST_MAP_C, ST_SQ_R: begin
        mul_a = zr;
        mul_b = zr;
      end
      ST_SQ_I: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  // in CROSS, rr holds zr^2 and prod holds zi^2 of the current z
  always_comb begin
    iter_lim = (cfg.iter_limit == '0) ? ITER_W'(1) : cfg.iter_limit;
    mag      = PROD_W'(rr) + PROD_W'(prod);
    stop     = (count != '0) && ((mag >= MAG_LIMIT) || (count >= iter_lim));
    re_sum   = ((rr - ii) >>> FRAC_BITS) + sext32(cr);
    im_sum   = (prod >>> (FRAC_BITS - 1)) + sext32(ci);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MAP_R;
          end
        end
        ST_MAP_R:  state <= ST_MAP_I;
        ST_MAP_I:  state <= ST_MAP_C;
        ST_MAP_C:  state <= ST_SQ_I;
        ST_SQ_R:   state <= ST_SQ_I;
        ST_SQ_I:   state <= ST_CROSS;
        ST_CROSS:  state <= stop ? ST_FINISH : ST_UPDATE;
        ST_UPDATE: state <= ST_SQ_R;
        ST_FINISH: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col_q <= column;
        row_q <= row;
        zr    <= '0;
        zi    <= '0;
        count <= '0;
      end
      ST_MAP_I: cr <= sat32(sext32(cfg.re_origin) + prod);
      ST_MAP_C: ci <= sat32(sext32(cfg.im_origin) + prod);
      ST_SQ_I:  rr <= prod;
      ST_CROSS: ii <= prod;
      ST_UPDATE: begin
        zr    <= sat32(re_sum);
        zi    <= sat32(im_sum);
        count <= count + ITER_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign idle       = (state == ST_IDLE);
  assign res.done   = (state == ST_FINISH);
  assign res.count  = count;

  `MET_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE), "not idle after reset")
  `MET_ASSERT(a_start_clears, (idle && start) |=> (count == '0), "count not cleared on start")
  `MET_ASSERT(a_count_step, (state == ST_UPDATE) |=> (count == $past(count) + ITER_W'(1)),
              "count did not advance by one")
  `MET_ASSERT(a_done_nonzero, res.done |-> (res.count != '0), "result with zero iterations")

endmodule

### rtl/core/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time engine for one pixel at a time, Q-format fixed point.
// ----------------------------------------------------------------------------
// Send a pixel request on s_tdata (column, row). The block maps it to the
// point c from the window registers and iterates z = z^2 + c from zero until
// |z|^2 reaches 4 or the count reaches the iteration limit (0 counts as 1).
// The result (iteration count and three color bytes) leaves on m_tdata.
// One signed 32x32 multiplier is shared: MAP_R, MAP_I and MAP_C map the
// pixel to c, each iteration takes three products and one update step, and
// the final magnitude check in CROSS is followed by FINISH and the output
// register, which raises m_tvalid. s_tready is high only while no pixel is
// in work, so a new request is taken only once the last one has left the
// engine. A finished result moves into the output register; while the
// receiver stalls, the next request is still taken and computed, then
// waits in the engine with s_tready low.
// Write the window registers through wr_en/wr_index/wr_data only while idle.
// rst (synchronous) drops any pixel in work, clears m_tvalid and
// loads the default window (-2.0, -2.0, step about 0.005, limit 500).
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 26
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // write port
  input  logic                                  wr_en,
  input  logic [met_pkg::IDX_W-1:0]             wr_index,
  input  logic [met_pkg::DATA_W-1:0]            wr_data,
  // pixel requests
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // column, row
  // results
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [39:0]                           m_tdata   // iterations, red, green, blue
);
  import met_pkg::*;

  cfg_t cfg;
  res_t res;

  logic               idle;
  logic               start;
  logic               take;
  logic [ITER_W-1:0]  iterations;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] cnt_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.re_origin  <= RST_RE_ORIGIN;
      cfg.im_origin  <= RST_IM_ORIGIN;
      cfg.real_step  <= RST_REAL_STEP;
      cfg.imag_step  <= RST_IMAG_STEP;
      cfg.iter_limit <= RST_ITER_LIMIT;
    end else if (wr_en) begin
      case (wr_index)
        CFG_RE_ORIGIN:  cfg.re_origin  <= wr_data;
        CFG_IM_ORIGIN:  cfg.im_origin  <= wr_data;
        CFG_REAL_STEP:  cfg.real_step  <= wr_data[STEP_W-1:0];
        CFG_IMAG_STEP:  cfg.imag_step  <= wr_data[STEP_W-1:0];
        CFG_ITER_LIMIT: cfg.iter_limit <= wr_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  assign take     = !m_tvalid || m_tready;

  met_iter #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_iter (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start),
    .column   (s_tdata[COORD_BITS-1:0]),
    .row      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .idle     (idle),
    .res      (res),
    .res_take (take)
  );

  assign cnt_lo = res.count[COLOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= res.done;
    end
  end

  // load color bytes with the count: 3n = n + 2n, 7n = 8n - n, all mod 256
  always_ff @(posedge clk) begin
    if (take && res.done) begin
      iterations <= res.count;
      red        <= cnt_lo;
      green      <= cnt_lo + {cnt_lo[COLOR_W-2:0], 1'b0};
      blue       <= {cnt_lo[COLOR_W-4:0], 3'b000} - cnt_lo;
    end
  end

  assign m_tdata = {blue, green, red, iterations};

endmodule

### dv/escape_time_checker.sv
// ----------------------------------------------------------------------------
// Escape-time pixel checker
// Watches the write port and both streams, works out the iteration count and
// color bytes of every pixel request and compares them with the results.
// ----------------------------------------------------------------------------
module escape_time_checker #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [met_pkg::IDX_W-1:0]         wr_index,
  input  logic [met_pkg::DATA_W-1:0]        wr_data,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,   // column, row
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [39:0]                       m_tdata,   // iterations, red, green, blue
  output int                                errors,
  output int                                pending
);
  import met_pkg::*;

  localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FRAC_BITS);

  typedef struct packed {
    logic [ITER_W-1:0]  iterations;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_color_t;

  cfg_t         window;
  pixel_color_t color_due[$];
  int           fail_count = 0;
  int           due_count = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  function automatic longint clamp32(input longint v);
    if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
    if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
    return v;
  endfunction

  // iterate z = z^2 + c at full product width until escape or the limit
  function automatic pixel_color_t escape_color(input cfg_t win,
                                                input logic [COORD_BITS-1:0] col,
                                                input logic [COORD_BITS-1:0] row);
    longint       cr, ci, zr, zi, rr, ii, ri, nr, ni;
    logic [63:0]  mag;
    int unsigned  n;
    pixel_color_t res;
    cr = clamp32(longint'($signed(win.re_origin)) +
                 longint'(col) * longint'({1'b0, win.real_step}));
    ci = clamp32(longint'($signed(win.im_origin)) +
                 longint'(row) * longint'({1'b0, win.imag_step}));
    zr = 0;
    zi = 0;
    n  = 0;
    do begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      nr = clamp32(((rr - ii) >>> FRAC_BITS) + cr);
      // doubling of the cross term: shift one place less
      ni = clamp32((ri >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      mag = 64'(zr * zr) + 64'(zi * zi);
      n++;
    end while (mag < ESCAPE_MAG && n < win.iter_limit);
    res.iterations = n[ITER_W-1:0];
    res.red        = n[COLOR_W-1:0];
    res.green      = 8'(n * 3);
    res.blue       = 8'(n * 7);
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_color_t seen, due;
    if (rst) begin
      window.re_origin  = RST_RE_ORIGIN;
      window.im_origin  = RST_IM_ORIGIN;
      window.real_step  = RST_REAL_STEP;
      window.imag_step  = RST_IMAG_STEP;
      window.iter_limit = RST_ITER_LIMIT;
      color_due.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_RE_ORIGIN:  window.re_origin  = wr_data;
          CFG_IM_ORIGIN:  window.im_origin  = wr_data;
          CFG_REAL_STEP:  window.real_step  = wr_data[STEP_W-1:0];
          CFG_IMAG_STEP:  window.imag_step  = wr_data[STEP_W-1:0];
          CFG_ITER_LIMIT: window.iter_limit = wr_data[ITER_W-1:0];
          default: ;
        endcase
      end
      // retire the result before queueing a new request
      if (m_tvalid && m_tready) begin
        seen.iterations = m_tdata[15:0];
        seen.red        = m_tdata[23:16];
        seen.green      = m_tdata[31:24];
        seen.blue       = m_tdata[39:32];
        if (color_due.size() == 0) begin
          $error("result with no pixel request outstanding: iterations %0d",
                 seen.iterations);
          fail_count++;
        end else begin
          due = color_due.pop_front();
          check_field("iterations", due.iterations, seen.iterations);
          check_field("red", due.red, seen.red);
          check_field("green", due.green, seen.green);
          check_field("blue", due.blue, seen.blue);
        end
      end
      if (s_tvalid && s_tready) begin
        color_due.push_back(escape_color(window, s_tdata[COORD_BITS-1:0],
                                         s_tdata[2*COORD_BITS-1:COORD_BITS]));
      end
    end
    due_count = color_due.size();
  end

endmodule

### dv/mandelbrot_escape_time_pixel_tb.sv
// ----------------------------------------------------------------------------
// Escape-time pixel engine testbench
// Drives pixel requests and window writes with random stalls on both sides;
// the checker beside the engine predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_tb;
  import met_pkg::*;

  localparam int COORD_BITS  = 11;
  localparam int FRAC_BITS   = 26;
  localparam int S_W         = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 5000000;

  logic              clk = 1'b0;
  logic              rst;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_index;
  logic [DATA_W-1:0] wr_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [S_W-1:0]    s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [39:0]       m_tdata;

  int   errors;
  int   pending;
  int   cycle_count = 0;
  logic calm;
  logic hold_off_req;

  mandelbrot_escape_time_pixel #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  escape_time_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (!calm && !rst && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  // call at a falling edge; returns at a falling edge after acceptance, at times after a random gap with s_tvalid low
  task automatic paint_pixel(input int col, input int row);
    s_tdata = '0;
    s_tdata[COORD_BITS-1:0] = col[COORD_BITS-1:0];
    s_tdata[2*COORD_BITS-1:COORD_BITS] = row[COORD_BITS-1:0];
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_window(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = value;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic load_window(input logic [DATA_W-1:0] rmin, input logic [DATA_W-1:0] imin,
                             input logic [DATA_W-1:0] rstep, input logic [DATA_W-1:0] istep,
                             input logic [DATA_W-1:0] limit);
    wait_drained();
    set_window(CFG_RE_ORIGIN, rmin);
    set_window(CFG_IM_ORIGIN, imin);
    set_window(CFG_REAL_STEP, rstep);
    set_window(CFG_IMAG_STEP, istep);
    set_window(CFG_ITER_LIMIT, limit);
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = CFG_RE_ORIGIN;
    wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // default window: corners, origin, points inside the set, bit walks
    paint_pixel(0, 0);
    paint_pixel(COORD_MAX, COORD_MAX);
    paint_pixel(400, 400);
    paint_pixel(0, 400);
    paint_pixel(300, 400);
    paint_pixel(350, 450);
    paint_pixel(11'h555, 11'h2AA);
    paint_pixel(11'h2AA, 11'h555);
    paint_pixel(COORD_MAX, 0);
    paint_pixel(0, COORD_MAX);

    // limit of zero acts as one
    load_window(32'hF8000000, 32'hF8000000, 335544, 335544, 0);
    paint_pixel(400, 400);
    paint_pixel(0, 0);
    wait_drained();
    set_window(CFG_ITER_LIMIT, 1);
    paint_pixel(400, 400);

    // saturated coordinates, step bit 31 masked off
    load_window(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    paint_pixel(COORD_MAX, 0);
    paint_pixel(0, COORD_MAX);
    paint_pixel(COORD_MAX, COORD_MAX);

    // |z|^2 lands exactly on 4, then a slow point at the cusp
    load_window(32'hF8000000, 32'h00000000, 0, 0, 100);
    paint_pixel(COORD_MAX, 11'h555);
    wait_drained();
    set_window(CFG_RE_ORIGIN, 32'h01000000);
    paint_pixel(11'h2AA, COORD_MAX);
    wait_drained();
    set_window(CFG_RE_ORIGIN, 32'h80000000);
    paint_pixel(5, 9);

    // origin at the largest limit
    load_window(32'h00000000, 32'h00000000, 0, 0, 16'hFFFF);
    paint_pixel(COORD_MAX, COORD_MAX);

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        load_window($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 64));
      end else begin
        load_window(32'(-167772160 + int'($urandom_range(0, 100663296))),
                    32'(-100663296 + int'($urandom_range(0, 50331648))),
                    $urandom_range(2000, 100000), $urandom_range(2000, 100000),
                    $urandom_range(1, 64));
      end
      if (p == 7) calm = 1'b1;
      for (int k = 0; k < 100; k++) begin
        if (p == 2 && k == 30) hold_off_req = 1'b1;
        if (p == 5 && k == 50) wait_drained();
        paint_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
